FILE: design/ssp_pkg.sv
// Shared types, register codes and sizes for the sprite screen projection block.
package ssp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Restoring divider sizes: lateral/depth quotient and column/size quotient.
  localparam int LD_QW  = 32;
  localparam int LD_DW  = 32;
  localparam int CS_QW  = 43;
  localparam int CS_DW  = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_POS_X   = 3'd0,
    REG_CAM_POS_Y   = 3'd1,
    REG_VIEW_DIR_X  = 3'd2,
    REG_VIEW_DIR_Y  = 3'd3,
    REG_CAM_PLANE_X = 3'd4,
    REG_CAM_PLANE_Y = 3'd5,
    REG_WIN_WIDTH   = 3'd6,
    REG_WIN_HEIGHT  = 3'd7
  } reg_idx_t;

  localparam logic signed [31:0] RST_CAM_POS_X   = 32'sd0;
  localparam logic signed [31:0] RST_CAM_POS_Y   = 32'sd0;
  localparam logic signed [15:0] RST_VIEW_DIR_X  = -16'sd16384;
  localparam logic signed [15:0] RST_VIEW_DIR_Y  = 16'sd0;
  localparam logic signed [15:0] RST_CAM_PLANE_X = 16'sd0;
  localparam logic signed [15:0] RST_CAM_PLANE_Y = 16'sd10813;
  localparam logic [11:0]        RST_WIN_WIDTH   = 12'd640;
  localparam logic [11:0]        RST_WIN_HEIGHT  = 12'd480;

  typedef struct packed {
    logic signed [31:0] sprite_x;
    logic signed [31:0] sprite_y;
  } ssp_in_t;

  typedef struct packed {
    logic signed [31:0] lateral;
    logic signed [31:0] depth;
    logic               visible;
    logic signed [15:0] screen_col;
    logic [15:0]        sprite_size;
    logic [11:0]        start_row;
    logic [11:0]        end_row;
    logic [11:0]        start_col;
    logic [11:0]        end_col;
  } ssp_out_t;

endpackage

FILE: design/ssp_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module ssp_div #(
  parameter int QW = 32,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_lo,
  input  logic [DW-1:0] in_dvs,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_q,
  output logic [SW-1:0] out_side
);

  logic          vld  [QW];
  logic [DW-1:0] rem  [QW];
  logic [QW-1:0] lo   [QW];
  logic [DW-1:0] dvs  [QW];
  logic [SW-1:0] side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          v_i;
    logic [DW-1:0] r_i;
    logic [DW-1:0] d_i;
    logic [QW-1:0] l_i;
    logic [SW-1:0] s_i;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_src
      assign v_i = in_vld;
      assign r_i = in_rem;
      assign d_i = in_dvs;
      assign l_i = in_lo;
      assign s_i = in_side;
    end else begin : g_src
      assign v_i = vld[k-1];
      assign r_i = rem[k-1];
      assign d_i = dvs[k-1];
      assign l_i = lo[k-1];
      assign s_i = side[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign t  = {r_i, l_i[QW-1]};
    assign ge = (t >= {1'b0, d_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? DW'(t - {1'b0, d_i}) : t[DW-1:0];
        lo[k]   <= {l_i[QW-2:0], ge};
        dvs[k]  <= d_i;
        side[k] <= s_i;
      end
    end
  end

  assign out_vld  = vld[QW-1];
  assign out_q    = lo[QW-1];
  assign out_side = side[QW-1];

endmodule

FILE: design/sprite_screen_projection.sv
// Top level of the sprite screen projection pipeline.
//
//   port group   dir  handshake            payload
//   in_*         in   in_valid / in_ready  ssp_in_t  (sprite world position)
//   out_*        out  out_valid / out_ready ssp_out_t (projection and draw limits)
//   cfg_*        in   cfg_we               cfg_idx, cfg_wdata (camera and window)
//
// One request enters per cycle while in_ready is high (skid entry empty).
// The pipe holds two bit-serial divider chains: 32 stages for lateral and
// depth, 43 stages for centre column and size, plus ten arithmetic stages and
// the output register. rst is synchronous and clears valid bits and config.
// A one-entry skid behind the output register lets the pipe advance while a
// result waits; the whole pipe holds only while the skid is full.
module sprite_screen_projection (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ssp_pkg::ssp_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ssp_pkg::ssp_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import ssp_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [31:0] cam_pos_x, cam_pos_y;
  logic signed [15:0] view_dir_x, view_dir_y, cam_plane_x, cam_plane_y;
  logic [11:0]        win_width, win_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_pos_x   <= RST_CAM_POS_X;
      cam_pos_y   <= RST_CAM_POS_Y;
      view_dir_x  <= RST_VIEW_DIR_X;
      view_dir_y  <= RST_VIEW_DIR_Y;
      cam_plane_x <= RST_CAM_PLANE_X;
      cam_plane_y <= RST_CAM_PLANE_Y;
      win_width   <= RST_WIN_WIDTH;
      win_height  <= RST_WIN_HEIGHT;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_CAM_POS_X:   cam_pos_x   <= cfg_wdata;
        REG_CAM_POS_Y:   cam_pos_y   <= cfg_wdata;
        REG_VIEW_DIR_X:  view_dir_x  <= cfg_wdata[15:0];
        REG_VIEW_DIR_Y:  view_dir_y  <= cfg_wdata[15:0];
        REG_CAM_PLANE_X: cam_plane_x <= cfg_wdata[15:0];
        REG_CAM_PLANE_Y: cam_plane_y <= cfg_wdata[15:0];
        REG_WIN_WIDTH:   win_width   <= cfg_wdata[11:0];
        REG_WIN_HEIGHT:  win_height  <= cfg_wdata[11:0];
      endcase
    end
  end

  // Determinant of [plane dir] follows config through det_r and dmag_r; both
  // settle after a write, well before any request reaches the dividers.
  logic signed [32:0] det_r;
  logic [31:0]        dmag_r;
  logic               det0_r;

  always_ff @(posedge clk) begin
    det_r  <= (cam_plane_x * view_dir_y) - (view_dir_x * cam_plane_y);
    dmag_r <= det_r[32] ? 32'(-det_r) : det_r[31:0];
    det0_r <= (det_r == '0);
  end

  // ---------------------------------------------------------------------
  // Pipe control: advance unless the skid entry is occupied
  // ---------------------------------------------------------------------
  logic adv;
  logic skid_v;

  assign adv      = !skid_v;
  assign in_ready = adv;

  // ---------------------------------------------------------------------
  // Stage 1: offset from camera
  // ---------------------------------------------------------------------
  logic               v1;
  logic signed [32:0] dx1, dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1 <= 33'(in_data.sprite_x) - 33'(cam_pos_x);
      dy1 <= 33'(in_data.sprite_y) - 33'(cam_pos_y);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: four 16x33 products
  // ---------------------------------------------------------------------
  logic               v2;
  logic signed [48:0] pl_a, pl_b, pd_a, pd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_a <= view_dir_y * dx1;
      pl_b <= view_dir_x * dy1;
      pd_a <= cam_plane_x * dy1;
      pd_b <= cam_plane_y * dx1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: numerators
  // ---------------------------------------------------------------------
  logic               v3;
  logic signed [49:0] nl3, nd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nl3 <= 50'(pl_a) - 50'(pl_b);
      nd3 <= 50'(pd_a) - 50'(pd_b);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: magnitudes of num * 2^14, split at bit 32, overflow check
  // ---------------------------------------------------------------------
  logic [49:0] nl_mag, nd_mag;
  logic        v4;
  logic [31:0] l_hi4, l_lo4, d_hi4, d_lo4;
  logic        l_ovf4, l_neg4, d_ovf4, d_neg4, det0_4;

  assign nl_mag = nl3[49] ? 50'(-nl3) : nl3;
  assign nd_mag = nd3[49] ? 50'(-nd3) : nd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_hi4  <= nl_mag[49:18];
      l_lo4  <= {nl_mag[17:0], 14'd0};
      l_ovf4 <= (nl_mag[49:18] >= dmag_r);
      l_neg4 <= nl3[49] ^ det_r[32];
      d_hi4  <= nd_mag[49:18];
      d_lo4  <= {nd_mag[17:0], 14'd0};
      d_ovf4 <= (nd_mag[49:18] >= dmag_r);
      d_neg4 <= nd3[49] ^ det_r[32];
      det0_4 <= det0_r;
    end
  end

  // Lateral and depth dividers run in lockstep.
  logic              vld_lat, vld_dep;
  logic [LD_QW-1:0]  q_lat, q_dep;
  logic [2:0]        sd_lat;
  logic [1:0]        sd_dep;

  ssp_div #(.QW(LD_QW), .DW(LD_DW), .SW(3)) u_div_lat (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v4),
    .in_rem   (l_hi4),
    .in_lo    (l_lo4),
    .in_dvs   (dmag_r),
    .in_side  ({l_ovf4, l_neg4, det0_4}),
    .out_vld  (vld_lat),
    .out_q    (q_lat),
    .out_side (sd_lat)
  );

  ssp_div #(.QW(LD_QW), .DW(LD_DW), .SW(2)) u_div_dep (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v4),
    .in_rem   (d_hi4),
    .in_lo    (d_lo4),
    .in_dvs   (dmag_r),
    .in_side  ({d_ovf4, d_neg4}),
    .out_vld  (vld_dep),
    .out_q    (q_dep),
    .out_side (sd_dep)
  );

  // Apply sign, saturate to 32 bits, force zero on a singular matrix.
  function automatic logic signed [31:0] sat_quot(input logic [31:0] q,
                                                  input logic ovf,
                                                  input logic neg,
                                                  input logic zero);
    logic signed [31:0] r;
    if (zero) begin
      r = '0;
    end else if (ovf || q[31]) begin
      r = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = neg ? -$signed(q) : $signed(q);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stage 5: lateral and depth
  // ---------------------------------------------------------------------
  logic               v5;
  logic signed [31:0] lat5, dep5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= vld_lat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat5 <= sat_quot(q_lat, sd_lat[2], sd_lat[1], sd_lat[0]);
      dep5 <= sat_quot(q_dep, sd_dep[1], sd_dep[0], sd_lat[0]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: depth + lateral, visibility
  // ---------------------------------------------------------------------
  logic               v6, vis6;
  logic signed [32:0] sum6;
  logic signed [31:0] lat6, dep6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum6 <= 33'(dep5) + 33'(lat5);
      vis6 <= (dep5 > 32'sd0);
      lat6 <= lat5;
      dep6 <= dep5;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: half width times (depth + lateral)
  // ---------------------------------------------------------------------
  logic               v7, vis7;
  logic signed [44:0] prod7;
  logic signed [31:0] lat7, dep7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod7 <= $signed({1'b0, win_width[11:1]}) * sum6;
      vis7  <= vis6;
      lat7  <= lat6;
      dep7  <= dep6;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: column dividend magnitude
  // ---------------------------------------------------------------------
  logic               v8, vis8, c_neg8;
  logic [CS_QW-1:0]   c_mag8;
  logic signed [31:0] lat8, dep8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_mag8 <= prod7[44] ? CS_QW'(-prod7) : prod7[CS_QW-1:0];
      c_neg8 <= prod7[44];
      vis8   <= vis7;
      lat8   <= lat7;
      dep8   <= dep7;
    end
  end

  // Column and size dividers, divisor is the low 31 bits of depth (positive when visible).
  logic              vld_col, vld_sz;
  logic [CS_QW-1:0]  q_col, q_sz;
  logic [64:0]       sd_col;
  logic              sd_sz;

  ssp_div #(.QW(CS_QW), .DW(CS_DW), .SW(65)) u_div_col (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v8),
    .in_rem   ('0),
    .in_lo    (c_mag8),
    .in_dvs   (dep8[CS_DW-1:0]),
    .in_side  ({c_neg8, lat8, dep8}),
    .out_vld  (vld_col),
    .out_q    (q_col),
    .out_side (sd_col)
  );

  ssp_div #(.QW(CS_QW), .DW(CS_DW), .SW(1)) u_div_sz (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v8),
    .in_rem   ('0),
    .in_lo    (CS_QW'({win_height, 16'd0})),
    .in_dvs   (dep8[CS_DW-1:0]),
    .in_side  (vis8),
    .out_vld  (vld_sz),
    .out_q    (q_sz),
    .out_side (sd_sz)
  );

  // ---------------------------------------------------------------------
  // Stage 9: signed column, size
  // ---------------------------------------------------------------------
  logic               v9, vis9;
  logic signed [43:0] col9;
  logic [27:0]        size9;
  logic signed [31:0] lat9, dep9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= vld_col;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col9  <= sd_col[64] ? -$signed({1'b0, q_col}) : $signed({1'b0, q_col});
      size9 <= q_sz[27:0];
      vis9  <= sd_sz;
      lat9  <= sd_col[63:32];
      dep9  <= sd_col[31:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 10: raw draw limits from centre and half size
  // ---------------------------------------------------------------------
  logic [26:0]        hs9;
  logic [10:0]        hh;
  logic               v10, vis10;
  logic signed [28:0] srow10;
  logic [27:0]        erow10;
  logic signed [45:0] scol10, ecol10;
  logic signed [43:0] col10;
  logic [27:0]        size10;
  logic signed [31:0] lat10, dep10;

  assign hs9 = size9[27:1];
  assign hh  = win_height[11:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (adv) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srow10 <= 29'(hh) - 29'(hs9);
      erow10 <= 28'(hs9) + 28'(hh);
      scol10 <= 46'(col9) - 46'(hs9) - 46'd1;
      ecol10 <= 46'(col9) + 46'(hs9) + 46'd1;
      col10  <= col9;
      size10 <= size9;
      vis10  <= vis9;
      lat10  <= lat9;
      dep10  <= dep9;
    end
  end

  // Clamp a column bound to [0, window width].
  function automatic logic [11:0] clamp_col(input logic signed [45:0] v,
                                            input logic [11:0] lim);
    logic [11:0] r;
    if (v[45]) begin
      r = '0;
    end else if (v > $signed(46'(lim))) begin
      r = lim;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  // Final clamps and saturation; hidden sprites report only lateral/depth.
  ssp_out_t res;

  always_comb begin
    res            = '0;
    res.lateral    = lat10;
    res.depth      = dep10;
    res.visible    = vis10;
    if (vis10) begin
      if (col10 > 44'sd32767) begin
        res.screen_col = 16'sh7fff;
      end else if (col10 < -44'sd32768) begin
        res.screen_col = 16'sh8000;
      end else begin
        res.screen_col = col10[15:0];
      end
      res.sprite_size = (|size10[27:16]) ? 16'hffff : size10[15:0];
      res.start_row   = srow10[28] ? 12'd0 : srow10[11:0];
      res.end_row     = (erow10 > 28'(win_height)) ? win_height : erow10[11:0];
      res.start_col   = clamp_col(scol10, win_width);
      res.end_col     = clamp_col(ecol10, win_width);
    end
  end

  // ---------------------------------------------------------------------
  // Output register with one skid entry
  // ---------------------------------------------------------------------
  ssp_out_t skid_data;
  logic     push;

  assign push = adv && v10;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      // output slot frees: drain skid first, else take the pipe
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= res;
      end
    end else if (push) begin
      skid_data <= res;
    end
  end

`ifndef SYNTHESIS
  // skid entry is only ever filled behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid holds a result while output is empty");

  // paired dividers must stay in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (vld_lat == vld_dep) && (vld_col == vld_sz))
    else $error("divider lanes out of step");

  a_visible_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.visible == (out_data.depth > 32'sd0)))
    else $error("visible flag disagrees with depth");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.visible) |->
      (out_data.sprite_size == '0 && out_data.end_row == '0 &&
       out_data.end_col == '0 && out_data.screen_col == '0))
    else $error("hidden sprite carries draw limits");
`endif

endmodule
